/* hw/rtl/csma_pkg.sv */
// csma_pkg: widths, register indexes and opcode/status codes for the
// unslotted CSMA-CA backoff engine. No dependencies.
package csma_pkg;

  localparam int RANDOM_WIDTH = 8;
  localparam int DELAY_WIDTH  = 18;

  localparam int BE_W      = 4;
  localparam int ATT_W     = 4;
  localparam int NB_W      = 3;
  localparam int UNIT_W    = 10;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 10;

  localparam int PROD_W = RANDOM_WIDTH + UNIT_W;
  localparam int SAT_W  = (PROD_W > DELAY_WIDTH) ? PROD_W : DELAY_WIDTH;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_BE       = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MAX_BE       = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_MAX_BACKOFFS = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_UNIT_TICKS   = CFG_IDX_W'(3);

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  localparam logic ST_CLEAR     = 1'b0;
  localparam logic ST_EXHAUSTED = 1'b1;

  localparam logic [BE_W-1:0]   RST_MIN_BE       = BE_W'(3);
  localparam logic [BE_W-1:0]   RST_MAX_BE       = BE_W'(5);
  localparam logic [NB_W-1:0]   RST_MAX_BACKOFFS = NB_W'(4);
  localparam logic [UNIT_W-1:0] RST_UNIT_TICKS   = UNIT_W'(20);

endpackage

/* hw/rtl/csma_delay_draw.sv */
// csma_delay_draw: backoff delay = (random AND (2^be - 1)) * unit_ticks,
// saturated to the countdown width. Depends on csma_pkg.
module csma_delay_draw import csma_pkg::*; (
  input  logic [BE_W-1:0]         be,
  input  logic [RANDOM_WIDTH-1:0] rnd,
  input  logic [UNIT_W-1:0]       unit_ticks,
  output logic [DELAY_WIDTH-1:0]  delay
);

  localparam logic [SAT_W-1:0] LIMIT = SAT_W'({DELAY_WIDTH{1'b1}});

  logic [RANDOM_WIDTH-1:0] mask;
  logic [PROD_W-1:0]       prod;
  logic [SAT_W-1:0]        prod_ext;

  always_comb begin
    for (int i = 0; i < RANDOM_WIDTH; i++) begin
      mask[i] = (i < int'(be));
    end
  end

  assign prod     = PROD_W'(rnd & mask) * PROD_W'(unit_ticks);
  assign prod_ext = SAT_W'(prod);
  assign delay    = (prod_ext > LIMIT) ? DELAY_WIDTH'(LIMIT) : DELAY_WIDTH'(prod_ext);

endmodule

/* hw/rtl/csma_ca_backoff_engine_core.sv */
// csma_ca_backoff_engine_core: unslotted CSMA-CA backoff engine top level.
// Depends on csma_pkg and csma_delay_draw.
//
//   channel | signals                                         | handshake
//   --------+-------------------------------------------------+-----------------
//   in      | opcode, random_byte, cca_clear                  | in_valid/in_stall
//   out     | access_status, attempts_used                    | out_valid/out_stall
//   cfg     | cfg_index, cfg_data                             | cfg_we
//
// One item per cycle while in_stall is low; state updates at the accepting edge,
// a result goes to out (skid if out held); the 8x10 multiply draw is combinational.
// Two-entry output buffer: in_stall rises only once both entries hold results.
// rst is synchronous, active high; all but the output and skid data registers reset.
module csma_ca_backoff_engine_core import csma_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    opcode,
  input  logic [RANDOM_WIDTH-1:0] random_byte,
  input  logic                    cca_clear,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    access_status,
  output logic [ATT_W-1:0]        attempts_used,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DAT_W-1:0]    cfg_data
);

  logic [BE_W-1:0]   min_be;
  logic [BE_W-1:0]   max_be;
  logic [NB_W-1:0]   max_backoffs;
  logic [UNIT_W-1:0] unit_ticks;

  logic                   busy, busy_next;
  logic [BE_W-1:0]        backoff_exponent, backoff_exponent_next;
  logic [ATT_W-1:0]       failed_attempts, failed_attempts_next;
  logic [DELAY_WIDTH-1:0] delay_remaining, delay_remaining_next;

  logic             skid_valid;
  logic             skid_status;
  logic [ATT_W-1:0] skid_attempts;

  logic             fire, pop, produce;
  logic             res_status;
  logic [ATT_W-1:0] res_attempts;
  logic [ATT_W-1:0] fa_inc;
  logic [BE_W:0]    be_sum;
  logic [BE_W-1:0]  be_inc;
  logic [BE_W-1:0]  draw_be;
  logic [DELAY_WIDTH-1:0] drawn;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_be       <= RST_MIN_BE;
      max_be       <= RST_MAX_BE;
      max_backoffs <= RST_MAX_BACKOFFS;
      unit_ticks   <= RST_UNIT_TICKS;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN_BE:       min_be       <= cfg_data[BE_W-1:0];
        REG_MAX_BE:       max_be       <= cfg_data[BE_W-1:0];
        REG_MAX_BACKOFFS: max_backoffs <= cfg_data[NB_W-1:0];
        REG_UNIT_TICKS:   unit_ticks   <= cfg_data[UNIT_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall = skid_valid;
  assign fire     = in_valid && !in_stall;
  assign pop      = out_valid && !out_stall;

  assign fa_inc  = failed_attempts + ATT_W'(1);
  assign be_sum  = {1'b0, backoff_exponent} + (BE_W+1)'(1);
  assign be_inc  = (be_sum > {1'b0, max_be}) ? max_be : be_sum[BE_W-1:0];
  assign draw_be = (opcode == OP_START) ? min_be : be_inc;

  csma_delay_draw u_draw (
    .be         (draw_be),
    .rnd        (random_byte),
    .unit_ticks (unit_ticks),
    .delay      (drawn)
  );

  always_comb begin
    busy_next             = busy;
    backoff_exponent_next = backoff_exponent;
    failed_attempts_next  = failed_attempts;
    delay_remaining_next  = delay_remaining;
    produce               = 1'b0;
    res_status            = ST_CLEAR;
    res_attempts          = failed_attempts;
    if (fire) begin
      if (opcode == OP_START) begin
        if (!busy) begin
          busy_next             = 1'b1;
          backoff_exponent_next = min_be;
          failed_attempts_next  = '0;
          delay_remaining_next  = drawn;
        end
      end else if (busy) begin
        if (delay_remaining != '0) begin
          delay_remaining_next = delay_remaining - DELAY_WIDTH'(1);
        end else if (cca_clear) begin
          busy_next = 1'b0;
          produce   = 1'b1;
        end else begin
          failed_attempts_next  = fa_inc;
          backoff_exponent_next = be_inc;
          if (fa_inc > ATT_W'(max_backoffs)) begin
            busy_next    = 1'b0;
            produce      = 1'b1;
            res_status   = ST_EXHAUSTED;
            res_attempts = fa_inc;
          end else begin
            delay_remaining_next = drawn;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy             <= 1'b0;
      backoff_exponent <= '0;
      failed_attempts  <= '0;
      delay_remaining  <= '0;
    end else begin
      busy             <= busy_next;
      backoff_exponent <= backoff_exponent_next;
      failed_attempts  <= failed_attempts_next;
      delay_remaining  <= delay_remaining_next;
    end
  end

  // output register plus skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= produce;
      end else begin
        out_valid  <= produce;
      end
    end else if (produce) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      if (skid_valid) begin
        access_status <= skid_status;
        attempts_used <= skid_attempts;
      end else begin
        access_status <= res_status;
        attempts_used <= res_attempts;
      end
    end
    if (produce && (skid_valid || (out_valid && !pop))) begin
      skid_status   <= res_status;
      skid_attempts <= res_attempts;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry holds an item while output register is empty");

  a_skid_on_stalled_result: assert property (@(posedge clk) disable iff (rst)
    (produce && out_valid && out_stall) |=> skid_valid)
    else $error("result produced behind a stalled output was not captured");

  a_end_has_result: assert property (@(posedge clk) disable iff (rst)
    (busy && !busy_next) |-> produce)
    else $error("access ended without a result");

  a_idle_no_delay: assert property (@(posedge clk) disable iff (rst)
    !busy |-> (delay_remaining == '0))
    else $error("countdown nonzero while idle");

endmodule
